// File: sv/double_ended_queue_top_defines.svh
// Assertion macros shared by the double-ended queue RTL.
// Included by files that carry concurrent assertions; needs clk and rst in scope.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// check a condition at every edge outside reset
`define DQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// check a consequence in the same cycle
`define DQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check a consequence in the next cycle
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/dq_pkg.sv
// Package for the double-ended queue: operation and status codes, cell and chain types.
// No dependencies; imported by dq_cell, dq_chain, double_ended_queue_top and the testbench.
`timescale 1ns / 1ps

package dq_pkg;

  localparam int VALUE_W    = 32;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - VALUE_W - STATUS_W;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_UP,
    SHIFT_DOWN
  } shift_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOWER,
    SEL_UPPER,
    SEL_LOAD
  } cell_sel_t;

  typedef struct packed {
    shift_t shift;
    logic   wr_en;
  } chain_ctl_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                last;
    value_t              value;
  } result_t;

endpackage

// File: sv/dq_cell.sv
// One storage cell of the queue chain: holds a value or takes a neighbour's or a load value.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_cell (
  input  logic              clk,
  input  dq_pkg::cell_sel_t sel,
  input  dq_pkg::value_t    lower,
  input  dq_pkg::value_t    upper,
  input  dq_pkg::value_t    load,
  output dq_pkg::value_t    q
);
  import dq_pkg::*;

  always_ff @(posedge clk) begin
    case (sel)
      SEL_HOLD:  q <= q;
      SEL_LOWER: q <= lower;
      SEL_UPPER: q <= upper;
      SEL_LOAD:  q <= load;
      default:   q <= q;
    endcase
  end

endmodule

// File: sv/dq_chain.sv
// Row of dq_cell instances that shifts up or down by one and loads one cell by position.
// Depends on dq_pkg and dq_cell.
`timescale 1ns / 1ps

module dq_chain #(
  parameter int DEPTH = 64,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  dq_pkg::chain_ctl_t ctl,
  input  logic [PW-1:0]      wr_pos,
  input  dq_pkg::value_t     wr_data,
  output dq_pkg::value_t     head,
  output dq_pkg::value_t     tail
);
  import dq_pkg::*;

  value_t cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int LO = (i == 0) ? 0 : i - 1;
    localparam int HI = (i == DEPTH - 1) ? i : i + 1;

    cell_sel_t sel;

    always_comb begin
      if (ctl.wr_en && wr_pos == PW'(i)) begin
        sel = SEL_LOAD;
      end else begin
        case (ctl.shift)
          SHIFT_UP:   sel = SEL_LOWER;
          SHIFT_DOWN: sel = SEL_UPPER;
          SHIFT_NONE: sel = SEL_HOLD;
          default:    sel = SEL_HOLD;
        endcase
      end
    end

    dq_cell u_cell (
      .clk   (clk),
      .sel   (sel),
      .lower (cells[LO]),
      .upper (cells[HI]),
      .load  (wr_data),
      .q     (cells[i])
    );
  end

  assign head = cells[0];
  assign tail = cells[DEPTH-1];

endmodule

// File: sv/double_ended_queue_top.sv
// Bounded double-ended queue of signed 32-bit values. Push front, push back, pop front and
// pop back each give one result beat. A dump of a queue holding N values gives N result
// beats, one per cycle while no result waits in the spare register, as the front row rotates
// through the cells. An empty dump gives one beat with status empty.
// Values sit in two rows of DEPTH cells: the front row keeps the front element in its first
// cell, the back row keeps the back element in its last cell, so every read is at a fixed cell.
// A result register plus one spare result register let an item be taken while a result waits.
// Depends on dq_pkg, dq_chain, dq_cell and double_ended_queue_top_defines.svh.
`timescale 1ns / 1ps
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dq_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] value
  input  logic [dq_pkg::KIND_W-1:0]     s_tuser,   // [2:0] kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dq_pkg::OUT_DATA_W-1:0] m_tdata,   // [31:0] result_value, [33:32] status
  output logic                          m_tlast
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic          state, state_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] occ_m1;
  logic          full, empty;
  logic          in_fire, out_free;

  chain_ctl_t    a_ctl, b_ctl;
  logic [PW-1:0] a_pos, b_pos;
  value_t        a_data;
  value_t        a_head, a_tail, b_head, b_tail;

  logic          emit;
  result_t       emit_res;
  result_t       out_res, pend_res;
  logic          pend_valid;

  logic          rows_match;
  logic          push_drop;

  assign full     = (occ == CW'(DEPTH));
  assign empty    = (occ == '0);
  assign occ_m1   = occ - CW'(1);
  assign s_tready = (state == ST_IDLE) && !pend_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    occ_next   = occ;
    cnt_next   = cnt;
    a_ctl      = '{shift: SHIFT_NONE, wr_en: 1'b0};
    b_ctl      = '{shift: SHIFT_NONE, wr_en: 1'b0};
    a_pos      = '0;
    b_pos      = '0;
    a_data     = s_tdata;
    emit       = 1'b0;
    emit_res   = '{status: STATUS_OK, last: 1'b1, value: '0};
    if (in_fire) begin
      case (s_tuser)
        KIND_PUSH_FRONT: begin
          emit = 1'b1;
          if (full) begin
            emit_res.status = STATUS_FULL;
          end else begin
            a_ctl    = '{shift: SHIFT_UP, wr_en: 1'b1};
            b_ctl    = '{shift: SHIFT_NONE, wr_en: 1'b1};
            b_pos    = PW'(DEPTH - 1) - occ[PW-1:0];
            occ_next = occ + CW'(1);
          end
        end
        KIND_PUSH_BACK: begin
          emit = 1'b1;
          if (full) begin
            emit_res.status = STATUS_FULL;
          end else begin
            a_ctl    = '{shift: SHIFT_NONE, wr_en: 1'b1};
            a_pos    = occ[PW-1:0];
            b_ctl    = '{shift: SHIFT_DOWN, wr_en: 1'b1};
            b_pos    = PW'(DEPTH - 1);
            occ_next = occ + CW'(1);
          end
        end
        KIND_POP_FRONT: begin
          emit = 1'b1;
          if (empty) begin
            emit_res.status = STATUS_EMPTY;
          end else begin
            emit_res.value = a_head;
            a_ctl          = '{shift: SHIFT_DOWN, wr_en: 1'b0};
            occ_next       = occ_m1;
          end
        end
        KIND_POP_BACK: begin
          emit = 1'b1;
          if (empty) begin
            emit_res.status = STATUS_EMPTY;
          end else begin
            emit_res.value = b_tail;
            b_ctl          = '{shift: SHIFT_UP, wr_en: 1'b0};
            occ_next       = occ_m1;
          end
        end
        KIND_DUMP: begin
          if (empty) begin
            emit            = 1'b1;
            emit_res.status = STATUS_EMPTY;
          end else begin
            state_next = ST_DUMP;
            cnt_next   = '0;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (state == ST_DUMP && !pend_valid) begin
      // rotate the front row: emit the head and put it back behind the last value
      emit           = 1'b1;
      emit_res.value = a_head;
      emit_res.last  = (cnt == occ_m1);
      a_ctl          = '{shift: SHIFT_DOWN, wr_en: 1'b1};
      a_pos          = occ_m1[PW-1:0];
      a_data         = a_head;
      cnt_next       = cnt + CW'(1);
      if (cnt == occ_m1) begin
        state_next = ST_IDLE;
      end
    end
  end

  dq_chain #(.DEPTH(DEPTH), .PW(PW)) u_front_row (
    .clk     (clk),
    .ctl     (a_ctl),
    .wr_pos  (a_pos),
    .wr_data (a_data),
    .head    (a_head),
    .tail    (a_tail)
  );

  dq_chain #(.DEPTH(DEPTH), .PW(PW)) u_back_row (
    .clk     (clk),
    .ctl     (b_ctl),
    .wr_pos  (b_pos),
    .wr_data (s_tdata),
    .head    (b_head),
    .tail    (b_tail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      occ        <= '0;
      cnt        <= '0;
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      cnt   <= cnt_next;
      if (pend_valid && out_free) begin
        m_tvalid   <= 1'b1;
        pend_valid <= 1'b0;
      end else if (emit && out_free) begin
        m_tvalid <= 1'b1;
      end else if (emit) begin
        pend_valid <= 1'b1;
      end else if (out_free) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && out_free) begin
      out_res <= pend_res;
    end else if (emit && out_free) begin
      out_res <= emit_res;
    end else if (emit) begin
      pend_res <= emit_res;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_res.status, out_res.value};
  assign m_tlast = out_res.last;

  assign rows_match = (a_head == b_head) && (a_tail == b_tail);
  assign push_drop  = in_fire && full &&
                      (s_tuser == KIND_PUSH_FRONT || s_tuser == KIND_PUSH_BACK);

  `DQ_ASSERT_ALWAYS(a_occ_bound, occ <= CW'(DEPTH), "occupancy beyond depth")
  `DQ_ASSERT_IMPL(a_spare_behind_out, pend_valid, m_tvalid, "spare result without output beat")
  `DQ_ASSERT_IMPL(a_dump_count, state == ST_DUMP, cnt < occ, "dump count past occupancy")
  `DQ_ASSERT_IMPL(a_mid_beat_ok, m_tvalid && !m_tlast, out_res.status == STATUS_OK, "bad mid beat")
  `DQ_ASSERT_IMPL(a_rows_full, full && state == ST_IDLE, rows_match, "rows differ when full")
  `DQ_ASSERT_NEXT(a_full_hold, push_drop, $stable(occ), "dropped push changed occupancy")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for double_ended_queue_top: directed corner cases, then random
// push/pop/dump bursts under four idling phases, checked beat by beat against a local model.
// Depends on dq_pkg and the double_ended_queue_top RTL.
`timescale 1ns / 1ps

module testbench;
  import dq_pkg::*;

  localparam int QDEPTH = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    value_t            value;
  } deque_op_t;

  typedef struct {
    value_t              value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } deque_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  deque_op_t     pending_ops[$];
  deque_result_t due_results[$];
  value_t        deque_model[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int beats_checked = 0;
  int ops_accepted = 0;
  int full_flags = 0;
  int empty_flags = 0;
  int dumps_seen = 0;
  int longest_dump = 0;

  double_ended_queue_top #(.DEPTH(QDEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic void apply_deque_op(input logic [KIND_W-1:0] kind, input value_t value);
    deque_result_t r;
    int n;
    r.value = '0;
    r.status = STATUS_OK;
    r.last = 1'b1;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (deque_model.size() >= QDEPTH) begin
          r.status = STATUS_FULL;
          full_flags++;
        end else if (kind == KIND_PUSH_FRONT) begin
          deque_model.push_front(value);
        end else begin
          deque_model.push_back(value);
        end
        due_results.push_back(r);
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (deque_model.size() == 0) begin
          r.status = STATUS_EMPTY;
          empty_flags++;
        end else if (kind == KIND_POP_FRONT) begin
          r.value = deque_model.pop_front();
        end else begin
          r.value = deque_model.pop_back();
        end
        due_results.push_back(r);
      end
      KIND_DUMP: begin
        dumps_seen++;
        n = deque_model.size();
        if (n == 0) begin
          r.status = STATUS_EMPTY;
          empty_flags++;
          due_results.push_back(r);
        end else begin
          if (n > longest_dump) longest_dump = n;
          for (int i = 0; i < n; i++) begin
            r.value = deque_model[i];
            r.last = (i == n - 1);
            due_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // sender: hold a beat until taken, then advance or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        s_tuser <= pending_ops[0].kind;
        s_tdata <= pending_ops[0].value;
        s_tvalid <= 1'b1;
        void'(pending_ops.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        ops_accepted++;
        apply_deque_op(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        beats_checked++;
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat value %0d status %0d last %0b", $time,
                   $signed(m_tdata[VALUE_W-1:0]), m_tdata[VALUE_W+STATUS_W-1:VALUE_W], m_tlast);
        end else begin
          want = due_results.pop_front();
          if (m_tdata[VALUE_W-1:0] !== want.value) begin
            mismatches++;
            $display("%0t: value expected %0d actual %0d", $time, want.value,
                     $signed(m_tdata[VALUE_W-1:0]));
          end
          if (m_tdata[VALUE_W+STATUS_W-1:VALUE_W] !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_tdata[VALUE_W+STATUS_W-1:VALUE_W]);
          end
          if (m_tlast !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, m_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic value_t pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(input logic [KIND_W-1:0] kind, input value_t value);
    deque_op_t op;
    op.kind = kind;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  task automatic queue_burst(input int count, input int push_pct, input int pop_pct,
                             input int dump_pct);
    logic [KIND_W-1:0] kind;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < push_pct)
        kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      else if (pick < push_pct + pop_pct)
        kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
      else if (pick < push_pct + pop_pct + dump_pct)
        kind = KIND_DUMP;
      else
        kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
      queue_op(kind, pick_value());
    end
  endtask

  // hold further beats until every outstanding result has arrived
  task automatic drain_results();
    while (pending_ops.size() != 0 || s_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    queue_op(KIND_POP_FRONT, 32'h1234_5678);
    queue_op(KIND_POP_BACK, 32'h0);
    queue_op(KIND_DUMP, 32'hffff_ffff);
    queue_op(KIND_SPARE_FIRST, 32'h1);
    queue_op(KIND_SPARE_MID, 32'h2);
    queue_op(KIND_SPARE_LAST, 32'hffff_ffff);
    queue_op(KIND_PUSH_BACK, 32'h7fff_ffff);
    queue_op(KIND_PUSH_FRONT, 32'h8000_0000);
    queue_op(KIND_PUSH_BACK, 32'h0);
    queue_op(KIND_PUSH_FRONT, 32'hffff_ffff);
    queue_op(KIND_PUSH_BACK, 32'h5555_5555);
    queue_op(KIND_PUSH_FRONT, 32'haaaa_aaaa);
    queue_op(KIND_DUMP, 32'h0);
    queue_op(KIND_POP_FRONT, 32'h0);
    queue_op(KIND_POP_BACK, 32'h0);
    queue_op(KIND_SPARE_FIRST, 32'h0);
    queue_op(KIND_POP_FRONT, 32'h0);
    queue_op(KIND_POP_BACK, 32'h0);
    queue_op(KIND_DUMP, 32'h0);
    queue_op(KIND_POP_FRONT, 32'h0);
    queue_op(KIND_POP_BACK, 32'h0);
    queue_op(KIND_DUMP, 32'h0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
        default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
      endcase
      queue_burst(75, 94, 1, 3);
      queue_burst(12, 45, 45, 8);
      queue_burst(14, 10, 85, 4);
      drain_results();
    end

    repeat (100) @(posedge clk);
    $display("%0d operations accepted, %0d result beats checked", ops_accepted, beats_checked);
    $display("%0d full drops, %0d empty flags, %0d dumps (longest %0d values)",
             full_flags, empty_flags, dumps_seen, longest_dump);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/dq_pkg.sv
sv/dq_cell.sv
sv/dq_chain.sv
sv/double_ended_queue_top.sv
verif/testbench.sv
